/* hdl/assert_macros.svh */
// Assertion macros used by the checker file dip_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define DIP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define DIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/dip_pkg.sv */
package dip_pkg;

    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [35:0] LIMIT_POS  = 36'd2147483647;
    localparam logic [35:0] LIMIT_NEG  = 36'd2147483648;
    localparam logic [31:0] NARROW_MAX = 32'd255;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } dip_in_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] parsed_value;
    } dip_out_t;

    typedef struct packed {
        logic [31:0] magnitude;
        logic        is_negative;
        logic        has_failed;
        logic        at_start;
    } dip_state_t;

    localparam dip_state_t STATE_START = '{
        magnitude:   32'd0,
        is_negative: 1'b0,
        has_failed:  1'b0,
        at_start:    1'b1
    };

endpackage

/* hdl/dip_char_step.sv */
module dip_char_step (
    input  dip_pkg::dip_state_t state_cur,
    input  dip_pkg::dip_in_t    item,
    input  logic                range_mode,
    output dip_pkg::dip_state_t state_upd,
    output dip_pkg::dip_out_t   result
);

    logic        is_minus;
    logic        non_digit;
    logic [3:0]  digit;
    logic [35:0] mag_times_ten;
    logic [35:0] mag_cand;
    logic [35:0] limit;
    logic        overflow;
    logic        take_digit;
    dip_pkg::dip_state_t after_char;
    logic        ok;
    logic [31:0] value;

    always_comb begin
        is_minus  = state_cur.at_start && (item.char_code == dip_pkg::CHAR_MINUS);
        non_digit = (item.char_code < dip_pkg::CHAR_ZERO) ||
                    (item.char_code > dip_pkg::CHAR_NINE);
        digit     = 4'(item.char_code - dip_pkg::CHAR_ZERO);

        // magnitude * 10 as (m << 3) + (m << 1)
        mag_times_ten = {1'b0, state_cur.magnitude, 3'b000} +
                        {3'b000, state_cur.magnitude, 1'b0};
        mag_cand      = mag_times_ten + 36'(digit);
        limit         = state_cur.is_negative ? dip_pkg::LIMIT_NEG : dip_pkg::LIMIT_POS;
        overflow      = mag_cand > limit;

        take_digit = !is_minus && !non_digit && !state_cur.has_failed && !overflow;

        after_char.at_start    = 1'b0;
        after_char.is_negative = state_cur.is_negative || is_minus;
        after_char.has_failed  = state_cur.has_failed ||
                                 (!is_minus && (non_digit || overflow));
        after_char.magnitude   = take_digit ? mag_cand[31:0] : state_cur.magnitude;

        ok    = !after_char.has_failed;
        value = after_char.is_negative ? (32'd0 - after_char.magnitude)
                                       : after_char.magnitude;
        // The narrow range allows a minus sign only in front of zero.
        if (range_mode && ((after_char.magnitude > dip_pkg::NARROW_MAX) ||
                           (after_char.is_negative && (after_char.magnitude != 32'd0)))) begin
            ok = 1'b0;
        end
        result.ok           = ok;
        result.parsed_value = ok ? $signed(value) : $signed(32'd0);

        state_upd = item.last_char ? dip_pkg::STATE_START : after_char;
    end

endmodule

/* hdl/decimal_int32_parser_top.sv */
// Decimal text to signed 32-bit integer parser. Characters enter on the s_ channel one
// item per cycle, the last character of a number marked by last_char; a leading '-' is
// taken only as the first character. One result leaves on the m_ channel for each marked
// character: ok and the value, or ok low with value zero on a bad character, overflow or
// a value outside the selected range. The result is registered: the last character sits in
// the input register, and the multiply-by-ten, add and limit compare load the result
// register when that character advances. Unmarked characters keep flowing at one per cycle while a
// result waits; a marked character holds in the input register, and stalls the input,
// until the waiting result is taken. cfg_data selects the range: 0 for the full signed
// 32-bit range, 1 for 0..255; write it only while no character is in flight.
module decimal_int32_parser_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dip_pkg::dip_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dip_pkg::dip_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    logic                in_valid_reg, in_valid_next;
    dip_pkg::dip_in_t    in_data_reg, in_data_next;
    dip_pkg::dip_state_t state_reg, state_next;
    logic                range_mode_reg, range_mode_next;
    logic                out_valid_reg, out_valid_next;
    dip_pkg::dip_out_t   out_data_reg, out_data_next;

    dip_pkg::dip_state_t state_upd;
    dip_pkg::dip_out_t   step_result;
    logic                advance;

    dip_char_step u_step (
        .state_cur  (state_reg),
        .item       (in_data_reg),
        .range_mode (range_mode_reg),
        .state_upd  (state_upd),
        .result     (step_result)
    );

    // A character without the last mark never needs the result register.
    assign advance = in_valid_reg &&
                     (!in_data_reg.last_char || !out_valid_reg || m_ready);

    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_data_next    = in_data_reg;
        state_next      = state_reg;
        range_mode_next = range_mode_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (s_ready) begin
            in_valid_next = s_valid;
            in_data_next  = s_data;
        end
        if (cfg_valid) begin
            range_mode_next = cfg_data;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            state_next = state_upd;
            if (in_data_reg.last_char) begin
                out_valid_next = 1'b1;
                out_data_next  = step_result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            state_reg      <= dip_pkg::STATE_START;
            range_mode_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            state_reg      <= state_next;
            range_mode_reg <= range_mode_next;
            out_valid_reg  <= out_valid_next;
        end
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* hdl/dip_checker.sv */
`include "assert_macros.svh"

module dip_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input dip_pkg::dip_out_t m_data
);

    // A result waiting on the consumer must not move or vanish.
    `DIP_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // A failed number always reports zero.
    `DIP_ASSERT(a_fail_zero, aclk, aresetn, m_valid && !m_data.ok |-> m_data.parsed_value == 32'sd0, "failed result with nonzero value")

    // Reset leaves no result pending and the input open.
    `DIP_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid && s_ready, "reset did not clear the channels")

endmodule

bind decimal_int32_parser_top dip_checker u_dip_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
